@@ sv/mfat_pkg.sv @@
package mfat_pkg;

    // ID window: slots id_base .. id_base+10
    localparam int ID_WINDOW = 11;
    localparam logic [10:0] ID_BASE_RST = 11'd513;

    // degree scaling: total taken modulo 36 turns, scaled to 360 degrees
    localparam int WRAP_TURNS  = 36;
    localparam int DEG_PER_REV = 360;
    localparam int DEG_W       = 9;   // |degrees| < 360

    // signed width for angle steps: +/-(65535 + 65536) fits
    localparam int STEP_W = 19;

    typedef struct packed {
        logic [3:0]         slot;
        logic [15:0]        angle;
        logic signed [15:0] speed;
        logic [15:0]        current;
        logic [7:0]         temp;
        logic signed [31:0] turn;
        logic signed [31:0] total;
    } t_fb;

endpackage

@@ sv/motor_feedback_angle_tracker.sv @@
// A request taken into the input stage passes one stage for the slot update and six for
// the degree scaling (reciprocal divides) before o_valid. Throughput: one request per
// cycle while i_stall is low; the slot state read-modify-write sits in one stage, so
// back-to-back frames for the same slot are handled without a bubble.
// Reset (i_rst_n low, synchronous): pipeline empties, id_base returns to 0x201 and every
// slot's previous angle, turn counter and accumulated counts are cleared to zero.
module motor_feedback_angle_tracker #(
    parameter int MOTOR_SLOTS     = 12,
    parameter int COUNTS_PER_TURN = 8192
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_wr_en,
    input  logic [10:0]         i_cfg_wr_data,
    // frame channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_from_motor_bus,
    input  logic [10:0]         i_std_id,
    input  logic [63:0]         i_payload,
    // feedback channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [3:0]          o_motor_slot,
    output logic [15:0]         o_rotor_angle,
    output logic signed [15:0]  o_speed_rpm,
    output logic [15:0]         o_motor_current,
    output logic [7:0]          o_temperature,
    output logic signed [31:0]  o_round_count,
    output logic signed [31:0]  o_total_count,
    output logic signed [9:0]   o_angle_degrees
);

    // ------------------------------------------------------------------
    // Derived constants
    // ------------------------------------------------------------------
    localparam int SLOT_W     = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
    localparam int SLOT_LIMIT = (MOTOR_SLOTS < mfat_pkg::ID_WINDOW) ? MOTOR_SLOTS
                                                                    : mfat_pkg::ID_WINDOW;
    localparam int SW         = mfat_pkg::STEP_W;
    localparam int DW         = mfat_pkg::DEG_W;

    // one full wrap of the degree scale, in counts
    localparam longint SPAN   = longint'(mfat_pkg::WRAP_TURNS) * COUNTS_PER_TURN;
    localparam int     SPAN_W = $clog2(SPAN + 1);
    // reciprocals scaled by 2^32; quotient estimates are at most one low
    localparam longint M_SPAN = (longint'(1) << 32) / SPAN;
    localparam int     Q1_W   = $clog2(M_SPAN + 1);
    localparam longint M_TURN = (longint'(1) << 32) / COUNTS_PER_TURN;
    // 10 * remainder < 360 * COUNTS_PER_TURN
    localparam int     Y_W    = $clog2(longint'(mfat_pkg::DEG_PER_REV) * COUNTS_PER_TURN);

    localparam logic signed [SW-1:0] STEP_TURN = SW'(COUNTS_PER_TURN);
    localparam logic signed [SW-1:0] STEP_HALF = SW'(COUNTS_PER_TURN / 2);

    // pipeline: 0 input, 1 state update, 2 magnitude, 3 span quotient,
    // 4 span remainder, 5 remainder fix and x10, 6 degree quotient, 7 result
    localparam int NSTG = 8;

    function automatic logic [31:0] abs_total(input logic signed [31:0] v);
        abs_total = v[31] ? 32'(-v) : 32'(v);
    endfunction

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [10:0] r_id_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_base <= mfat_pkg::ID_BASE_RST;
        end else if (i_cfg_wr_en) begin
            r_id_base <= i_cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: each stage loads when empty or when it hands on.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] go;
    logic            hit;

    always_comb begin
        go[NSTG-1] = r_vld[NSTG-1] && !i_stall;
        en[NSTG-1] = !r_vld[NSTG-1] || go[NSTG-1];
        for (int k = NSTG - 2; k >= 0; k--) begin
            go[k] = r_vld[k] && en[k+1];
            en[k] = !r_vld[k] || go[k];
        end
    end

    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            // frames outside the window drop out here
            if (en[1]) r_vld[1] <= r_vld[0] && hit;
            for (int k = 2; k < NSTG; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: input register
    // ------------------------------------------------------------------
    logic        r_fr_bus;
    logic [10:0] r_fr_id;
    logic [63:0] r_fr_pl;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_fr_bus <= i_from_motor_bus;
            r_fr_id  <= i_std_id;
            r_fr_pl  <= i_payload;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0 -> 1: slot decode and per-slot read-modify-write
    // ------------------------------------------------------------------
    logic [15:0]        r_prev [MOTOR_SLOTS];
    logic signed [31:0] r_turn [MOTOR_SLOTS];
    logic signed [31:0] r_acc  [MOTOR_SLOTS];

    logic [10:0]        id_diff;
    logic [SLOT_W-1:0]  idx;
    logic [15:0]        angle;
    logic [15:0]        last;
    logic signed [SW-1:0] d;
    logic signed [SW-1:0] r1;
    logic [SW-1:0]      mag1;
    logic [SW-1:0]      mag2;
    logic signed [SW-1:0] step;
    logic signed [31:0] n_turn;
    logic signed [31:0] n_total;
    mfat_pkg::t_fb      n_fb;

    always_comb begin
        id_diff = r_fr_id - r_id_base;
        hit     = r_fr_bus && (r_fr_id >= r_id_base) && (id_diff < 11'(SLOT_LIMIT));
        idx     = id_diff[SLOT_W-1:0];

        angle = r_fr_pl[63:48];
        last  = r_prev[idx];
        d     = $signed({3'b000, angle}) - $signed({3'b000, last});

        // turn counter steps the opposite way to a large jump
        if (d > STEP_HALF) begin
            n_turn = r_turn[idx] - 32'sd1;
        end else if (d < -STEP_HALF) begin
            n_turn = r_turn[idx] + 32'sd1;
        end else begin
            n_turn = r_turn[idx];
        end

        // shorter way round; a tie keeps the plain difference
        r1   = (angle < last) ? (d + STEP_TURN) : (d - STEP_TURN);
        mag1 = r1[SW-1] ? SW'(-r1) : SW'(r1);
        mag2 = d[SW-1]  ? SW'(-d)  : SW'(d);
        step = (mag1 < mag2) ? r1 : d;

        n_total = r_acc[idx] + 32'(step);

        n_fb.slot    = id_diff[3:0];
        n_fb.angle   = angle;
        n_fb.speed   = $signed(r_fr_pl[47:32]);
        n_fb.current = r_fr_pl[31:16];
        n_fb.temp    = r_fr_pl[15:8];
        n_fb.turn    = n_turn;
        n_fb.total   = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < MOTOR_SLOTS; s++) begin
                r_prev[s] <= '0;
                r_turn[s] <= '0;
                r_acc[s]  <= '0;
            end
        end else if (go[0] && hit) begin
            r_prev[idx] <= angle;
            r_turn[idx] <= n_turn;
            r_acc[idx]  <= n_total;
        end
    end

    // decoded feedback travels alongside the degree arithmetic
    mfat_pkg::t_fb r_fb [1:NSTG-1];

    always_ff @(posedge i_clk) begin
        if (en[1]) r_fb[1] <= n_fb;
        for (int k = 2; k < NSTG; k++) begin
            if (en[k]) r_fb[k] <= r_fb[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Degrees: |total| mod SPAN, then floor(10 * rem / COUNTS_PER_TURN),
    // sign taken from the total (truncating division).
    // ------------------------------------------------------------------
    logic [31:0]       r_x2;
    logic [31:0]       r_x3;
    logic [Q1_W-1:0]   r_q1;
    logic [SPAN_W:0]   r_rem4;
    logic [Y_W-1:0]    r_y5;
    logic [Y_W-1:0]    r_y6;
    logic [DW-1:0]     r_q2;
    logic signed [9:0] r_deg;

    logic [63:0]       p1;
    logic [63:0]       p_span;
    logic [31:0]       n_rem4;
    logic [SPAN_W-1:0] rem_fix;
    logic [Y_W-1:0]    n_y5;
    logic [63:0]       p2;
    logic [63:0]       p_turn;
    logic [Y_W-1:0]    rem_deg;
    logic [DW-1:0]     q_deg;

    always_comb begin
        // stage 2 -> 3
        p1 = 64'(r_x2) * 64'(M_SPAN);
        // stage 3 -> 4
        p_span = 64'(r_q1) * 64'(SPAN);
        n_rem4 = r_x3 - p_span[31:0];
        // stage 4 -> 5: estimate may be one span high
        rem_fix = (r_rem4 >= (SPAN_W + 1)'(SPAN)) ? SPAN_W'(r_rem4 - (SPAN_W + 1)'(SPAN))
                                                  : SPAN_W'(r_rem4);
        n_y5 = Y_W'({rem_fix, 3'b000}) + Y_W'({rem_fix, 1'b0});
        // stage 5 -> 6
        p2 = 64'(r_y5) * 64'(M_TURN);
        // stage 6 -> 7: quotient may be one low
        p_turn  = 64'(r_q2) * 64'(COUNTS_PER_TURN);
        rem_deg = r_y6 - Y_W'(p_turn);
        q_deg   = (rem_deg >= Y_W'(COUNTS_PER_TURN)) ? (r_q2 + DW'(1)) : r_q2;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_x2 <= abs_total(r_fb[1].total);
        end
        if (en[3]) begin
            r_x3 <= r_x2;
            r_q1 <= p1[32 +: Q1_W];
        end
        if (en[4]) begin
            r_rem4 <= n_rem4[SPAN_W:0];
        end
        if (en[5]) begin
            r_y5 <= n_y5;
        end
        if (en[6]) begin
            r_y6 <= r_y5;
            r_q2 <= p2[32 +: DW];
        end
        if (en[7]) begin
            r_deg <= r_fb[6].total[31] ? -$signed({1'b0, q_deg}) : $signed({1'b0, q_deg});
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    assign o_valid         = r_vld[NSTG-1];
    assign o_motor_slot    = r_fb[NSTG-1].slot;
    assign o_rotor_angle   = r_fb[NSTG-1].angle;
    assign o_speed_rpm     = r_fb[NSTG-1].speed;
    assign o_motor_current = r_fb[NSTG-1].current;
    assign o_temperature   = r_fb[NSTG-1].temp;
    assign o_round_count   = r_fb[NSTG-1].turn;
    assign o_total_count   = r_fb[NSTG-1].total;
    assign o_angle_degrees = r_deg;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

    // block geometry, as built by default
    localparam int SLOTS     = 12;
    localparam int CPT       = 8192;              // encoder counts per turn
    localparam int HALF_TURN = CPT / 2;
    localparam longint SPAN  = 36 * 8192;         // degree wrap: 36 turns
    localparam int DRAIN_CYCLES = 12;             // drain wait after the last accept: pipeline depth plus margin

    typedef struct packed {
        logic [3:0]         slot;
        logic [15:0]        angle;
        logic signed [15:0] speed;
        logic [15:0]        current;
        logic [7:0]         temp;
        logic signed [31:0] turns;
        logic signed [31:0] total;
        logic signed [9:0]  deg;
    } t_feedback;

    // one row of the directed script: typed rows carry their own answer
    typedef struct packed {
        logic        bus;
        logic [10:0] id;
        logic [63:0] data;
        logic        typed;
        logic        hit;
        t_feedback   want;
    } t_frame_row;

    localparam int N_ROWS = 23;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [10:0]       i_cfg_wr_data = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_from_motor_bus = 1'b0;
    logic [10:0]       i_std_id = '0;
    logic [63:0]       i_payload = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [3:0]        o_motor_slot;
    logic [15:0]       o_rotor_angle;
    logic signed [15:0] o_speed_rpm;
    logic [15:0]       o_motor_current;
    logic [7:0]        o_temperature;
    logic signed [31:0] o_round_count;
    logic signed [31:0] o_total_count;
    logic signed [9:0] o_angle_degrees;

    // tracker state mirrored on the testbench side
    logic [10:0]        slot0_id;
    logic [15:0]        slot_angle [SLOTS];
    logic signed [31:0] turn_count [SLOTS];
    logic signed [31:0] count_total [SLOTS];

    t_feedback pending_fb [$];      // feedback still owed by the block
    int        fail_count = 0;
    int        shown = 0;
    bit        gaps_on = 1'b1;      // random idling on both sides
    int        hold_left = 0;

    // directed script, reset value of the ID base (0x201) assumed
    t_frame_row script [N_ROWS] = '{
        // first frame of slot 0 from angle 0: nothing moves
        '{1'b1, 11'd513, 64'h0000_0000_0000_0000, 1'b1, 1'b1,
          '{4'd0, 16'd0, 16'sd0, 16'd0, 8'd0, 32'sd0, 32'sd0, 10'sd0}},
        // exactly half a turn: tie keeps the plain step, byte 7 ignored
        '{1'b1, 11'd514, 64'h1000_7FFF_FFFF_FFAA, 1'b1, 1'b1,
          '{4'd1, 16'd4096, 16'sd32767, 16'd65535, 8'd255, 32'sd0, 32'sd4096, 10'sd5}},
        // one past half a turn: wraps backwards, most negative speed
        '{1'b1, 11'd515, 64'h1001_8000_0000_0000, 1'b1, 1'b1,
          '{4'd2, 16'd4097, -16'sd32768, 16'd0, 8'd0, -32'sd1, -32'sd4095, -10'sd4}},
        // not from the motor bus
        '{1'b0, 11'd513, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, '0},
        // just below the window
        '{1'b1, 11'd512, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, '0},
        // first slot past the window
        '{1'b1, 11'd524, 64'h2000_1111_2222_3344, 1'b1, 1'b0, '0},
        // top of the ID range
        '{1'b1, 11'h7FF, 64'h5555_AAAA_5555_AAAA, 1'b1, 1'b0, '0},
        // top slot, largest raw angle used as given
        '{1'b1, 11'd523, 64'hFFFF_0001_0002_0300, 1'b1, 1'b1,
          '{4'd10, 16'd65535, 16'sd1, 16'd2, 8'd3, -32'sd1, 32'sd57343, 10'sd69}},
        // step back across zero: negative total truncates to 0 degrees
        '{1'b1, 11'd513, 64'h1FFF_0000_0000_0000, 1'b1, 1'b1,
          '{4'd0, 16'd8191, 16'sd0, 16'd0, 8'd0, -32'sd1, -32'sd1, 10'sd0}},
        '{1'b1, 11'd513, 64'h0000_1234_5678_9A00, 1'b0, 1'b0, '0},
        '{1'b1, 11'd514, 64'h0000_FFFF_8000_7F11, 1'b0, 1'b0, '0},
        '{1'b1, 11'd516, 64'h2000_0100_0200_4000, 1'b0, 1'b0, '0},
        '{1'b1, 11'd516, 64'h4000_0000_0000_0000, 1'b0, 1'b0, '0},
        '{1'b1, 11'd516, 64'h0000_0000_0000_0000, 1'b0, 1'b0, '0},
        '{1'b1, 11'd523, 64'h0000_AAAA_5555_AA55, 1'b0, 1'b0, '0},
        '{1'b1, 11'd517, 64'hAAAA_5555_AAAA_5555, 1'b0, 1'b0, '0},
        '{1'b1, 11'd517, 64'h5555_AAAA_5555_AAAA, 1'b0, 1'b0, '0},
        '{1'b1, 11'd518, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
        '{1'b1, 11'd518, 64'h0000_0000_0000_0000, 1'b0, 1'b0, '0},
        '{1'b1, 11'd519, 64'h0FFF_0000_0000_0000, 1'b0, 1'b0, '0},
        '{1'b1, 11'd519, 64'h0000_0000_0000_0000, 1'b0, 1'b0, '0},
        '{1'b1, 11'd520, 64'hE000_7FFF_0000_0000, 1'b0, 1'b0, '0},
        '{1'b1, 11'd522, 64'h7FFF_8001_FFFE_0180, 1'b0, 1'b0, '0}
    };

    motor_feedback_angle_tracker uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_from_motor_bus (i_from_motor_bus),
        .i_std_id         (i_std_id),
        .i_payload        (i_payload),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_motor_slot     (o_motor_slot),
        .o_rotor_angle    (o_rotor_angle),
        .o_speed_rpm      (o_speed_rpm),
        .o_motor_current  (o_motor_current),
        .o_temperature    (o_temperature),
        .o_round_count    (o_round_count),
        .o_total_count    (o_total_count),
        .o_angle_degrees  (o_angle_degrees)
    );

    always #10 i_clk = ~i_clk;

    // Unwrap one frame against the mirrored slot state. Returns 1 when the
    // frame selects a slot and so produces feedback.
    function automatic bit unwrap_frame(input logic bus, input logic [10:0] id,
                                        input logic [63:0] data, output t_feedback fb);
        int     slot;
        int     angle;
        int     last;
        int     d;
        int     alt;
        int     step;
        longint tot;
        longint deg;
        fb = '0;
        if (!bus || id < slot0_id)
            return 1'b0;
        slot = int'(id) - int'(slot0_id);
        if (slot >= mfat_pkg::ID_WINDOW || slot >= SLOTS)
            return 1'b0;
        angle = int'(data[63:48]);
        last  = int'(slot_angle[slot]);
        slot_angle[slot] = data[63:48];
        d = angle - last;
        if (d > HALF_TURN)
            turn_count[slot] = turn_count[slot] - 1;
        else if (d < -HALF_TURN)
            turn_count[slot] = turn_count[slot] + 1;
        // the way round the circle, opposite sense to the plain difference
        alt  = (angle < last) ? d + CPT : d - CPT;
        step = ((alt < 0 ? -alt : alt) < (d < 0 ? -d : d)) ? alt : d;
        count_total[slot] = count_total[slot] + step;
        tot = count_total[slot];
        // % and / truncate toward zero, so degrees keep the sign of the total
        deg = ((tot % SPAN) * 360) / SPAN;
        fb.slot    = slot[3:0];
        fb.angle   = data[63:48];
        fb.speed   = data[47:32];
        fb.current = data[31:16];
        fb.temp    = data[15:8];
        fb.turns   = turn_count[slot];
        fb.total   = count_total[slot];
        fb.deg     = deg[9:0];
        return 1'b1;
    endfunction

    function automatic string describe(input t_feedback fb);
        return $sformatf("slot %0d angle %0d speed %0d cur %0d temp %0d turns %0d total %0d deg %0d",
                         fb.slot, fb.angle, fb.speed, fb.current, fb.temp,
                         fb.turns, fb.total, fb.deg);
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic offer_frame(input logic bus, input logic [10:0] id, input logic [63:0] data);
        i_valid          <= 1'b1;
        i_from_motor_bus <= bus;
        i_std_id         <= id;
        i_payload        <= data;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Sender-side gap after an accepted request, in random bursts.
    task automatic sender_gap();
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Wait for all owed feedback, then let any frame without feedback clear
    // the pipeline before the register may be touched.
    task automatic drain_block();
        while (pending_fb.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_id_base(input logic [10:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        slot0_id = value;
    endtask

    // receiver back-pressure, in random bursts
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (gaps_on && i_rst_n && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 18) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // feedback checker: in-order against the oldest owed result
    always @(posedge i_clk) begin
        t_feedback seen;
        t_feedback want;
        if (i_rst_n && o_valid && !i_stall) begin
            seen = '{o_motor_slot, o_rotor_angle, o_speed_rpm, o_motor_current,
                     o_temperature, o_round_count, o_total_count, o_angle_degrees};
            if (pending_fb.size() == 0) begin
                fail_count++;
                if (shown < 10)
                    $display("tb mismatch @%0t: unexpected feedback %s",
                             $realtime, describe(seen));
                shown++;
            end else begin
                want = pending_fb.pop_front();
                if (seen !== want) begin
                    fail_count++;
                    if (shown < 10) begin
                        $display("tb mismatch @%0t: expected %s", $realtime, describe(want));
                        $display("                 actual   %s", describe(seen));
                    end
                    shown++;
                end
            end
        end
    end

    initial begin
        logic [10:0] phase_base [7];
        t_feedback   fb;
        bit          got;
        logic        bus;
        logic [10:0] id;
        logic [63:0] data;
        int          ph;
        int          hits;
        int          n;
        int          top;
        int          s;
        int          a;
        int          bias;
        int          sel;

        slot0_id = mfat_pkg::ID_BASE_RST;
        for (int k = 0; k < SLOTS; k++) begin
            slot_angle[k]  = '0;
            turn_count[k]  = '0;
            count_total[k] = '0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset value of the ID base
        for (int r = 0; r < N_ROWS; r++) begin
            offer_frame(script[r].bus, script[r].id, script[r].data);
            got = unwrap_frame(script[r].bus, script[r].id, script[r].data, fb);
            if (script[r].typed) begin
                if (script[r].hit)
                    pending_fb.push_back(script[r].want);
            end else if (got) begin
                pending_fb.push_back(fb);
            end
            sender_gap();
        end
        i_valid <= 1'b0;

        // random part: one ID base per phase, extremes included
        phase_base[0] = 11'd0;
        phase_base[1] = 11'd2047;
        phase_base[2] = 11'd2037;                  // window ends exactly at the top
        phase_base[3] = 11'($urandom_range(0, 2047));
        phase_base[4] = 11'd2040;                  // window clipped at the top
        phase_base[5] = 11'($urandom_range(0, 2047));
        phase_base[6] = mfat_pkg::ID_BASE_RST;

        for (ph = 0; ph < 7; ph++) begin
            drain_block();
            write_id_base(phase_base[ph]);
            top = 2047 - int'(slot0_id);
            if (top > mfat_pkg::ID_WINDOW - 1)
                top = mfat_pkg::ID_WINDOW - 1;
            bias = int'($urandom_range(0, 2)) - 1;   // drift so totals pass the degree wrap
            hits = 0;
            n = 0;
            while (hits < 150) begin
                // the final phase runs flat out, earlier ones mix in quiet stretches
                if (ph == 6)
                    gaps_on = 1'b0;
                else if (n % 64 == 0)
                    gaps_on = ($urandom_range(0, 2) != 0);
                sel = $urandom_range(0, 99);
                if (sel < 10) begin
                    bus  = 1'($urandom());
                    id   = 11'($urandom());
                    data = {$urandom(), $urandom()};
                end else if (sel < 16) begin
                    bus  = 1'b1;
                    if ($urandom_range(0, 1))
                        id = slot0_id + 11'($urandom_range(11, 15));
                    else
                        id = slot0_id - 11'($urandom_range(1, 4));
                    data = {$urandom(), $urandom()};
                end else begin
                    bus = 1'b1;
                    s   = $urandom_range(0, top);
                    id  = slot0_id + 11'(s);
                    case ($urandom_range(0, 9))
                        0: a = $urandom_range(0, 65535);
                        1: begin
                            case ($urandom_range(0, 5))
                                0: a = 0;
                                1: a = CPT - 1;
                                2: a = CPT;
                                3: a = 65535;
                                4: a = int'(slot_angle[s])
                                       + ($urandom_range(0, 1) ? 4096 : -4096);
                                default: a = int'(slot_angle[s])
                                             + ($urandom_range(0, 1) ? 4097 : -4097);
                            endcase
                        end
                        default: a = (int'(slot_angle[s]) % CPT + int'($urandom_range(0, 4096))
                                      - 2048 + bias * 1500) & (CPT - 1);
                    endcase
                    data = {a[15:0], 32'($urandom()), 16'($urandom())};
                end
                offer_frame(bus, id, data);
                if (unwrap_frame(bus, id, data, fb)) begin
                    pending_fb.push_back(fb);
                    hits++;
                end
                n++;
                sender_gap();
            end
            i_valid <= 1'b0;
        end

        // wind down: all feedback in, then a drain wait for stray output
        n = 0;
        while (pending_fb.size() != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_fb.size() != 0) begin
            $display("tb mismatch: %0d feedback results never arrived", pending_fb.size());
            fail_count += pending_fb.size();
        end
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
sv/mfat_pkg.sv
sv/motor_feedback_angle_tracker.sv
sim/tb.sv
